@@ hdl/rrtt_pkg.sv @@
`timescale 1ns / 1ps

package rrtt_pkg;

    localparam int SLOTS_DEFAULT = 16;

    // command codes
    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_DESTROY = 3'd1;
    localparam logic [2:0] CMD_SET_CUR = 3'd2;
    localparam logic [2:0] CMD_PICK    = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pid;
        logic [3:0]  slot;
        logic        live;
        logic [63:0] entry;
    } t_result;

    typedef struct packed {
        logic [31:0] pid;
        logic        live;
        logic [63:0] entry;
    } t_rd_data;

    typedef struct packed {
        logic        create;
        logic        free;
        logic [31:0] pid;
        logic [63:0] entry;
    } t_wr_req;

endpackage

@@ hdl/rrtt_store.sv @@
`timescale 1ns / 1ps

module rrtt_store #(
    parameter int SLOTS = rrtt_pkg::SLOTS_DEFAULT,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IW-1:0]     i_rd_addr,
    output rrtt_pkg::t_rd_data o_rd,
    input  logic [IW-1:0]     i_wr_addr,
    input  rrtt_pkg::t_wr_req i_wr
);

    logic [31:0]      r_pid_mem   [SLOTS];
    logic [63:0]      r_entry_mem [SLOTS];
    logic [SLOTS-1:0] r_live;
    logic [SLOTS-1:0] r_written;
    logic [31:0]      r_rd_pid;
    logic [63:0]      r_rd_entry;
    logic             r_rd_live;
    logic             r_rd_written;

    // pid and entry storage, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.create) begin
            r_pid_mem[i_wr_addr]   <= i_wr.pid;
            r_entry_mem[i_wr_addr] <= i_wr.entry;
        end
        r_rd_pid   <= r_pid_mem[i_rd_addr];
        r_rd_entry <= r_entry_mem[i_rd_addr];
    end

    // per-slot live and written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live       <= '0;
            r_written    <= '0;
            r_rd_live    <= 1'b0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr.create) begin
                r_live[i_wr_addr]    <= 1'b1;
                r_written[i_wr_addr] <= 1'b1;
            end else if (i_wr.free) begin
                r_live[i_wr_addr] <= 1'b0;
            end
            r_rd_live    <= r_live[i_rd_addr];
            r_rd_written <= r_written[i_rd_addr];
        end
    end

    // a never-written slot reads as pid zero
    assign o_rd.pid   = r_rd_written ? r_rd_pid : 32'd0;
    assign o_rd.live  = r_rd_live;
    assign o_rd.entry = r_rd_entry;

endmodule

@@ hdl/rrtt_ctrl.sv @@
`timescale 1ns / 1ps

module rrtt_ctrl #(
    parameter int SLOTS = rrtt_pkg::SLOTS_DEFAULT,
    localparam int IW = $clog2(SLOTS),
    localparam int LCW = $clog2(SLOTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [31:0]        i_task_id,
    input  logic [63:0]        i_entry_addr,
    input  logic [31:0]        i_stack_bytes,
    input  logic [7:0]         i_slot_index,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output rrtt_pkg::t_result  o_res,
    output logic [4:0]         o_live_count,
    output logic [IW-1:0]      o_rd_addr,
    input  rrtt_pkg::t_rd_data i_rd,
    output logic [IW-1:0]      o_wr_addr,
    output rrtt_pkg::t_wr_req  o_wr
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_FWAIT = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    function automatic logic [3:0] f_slot4(input logic [IW-1:0] idx);
        logic [IW+3:0] w;
        w = {4'd0, idx};
        return w[3:0];
    endfunction

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [31:0]       r_tid, n_tid;
    logic [63:0]       r_entry, n_entry;
    logic [7:0]        r_sidx, n_sidx;
    logic [IW:0]       r_cnt, n_cnt;
    logic              r_dv, n_dv;
    logic [IW-1:0]     r_chk, n_chk;
    logic [IW-1:0]     r_fadr, n_fadr;
    logic [31:0]       r_ref, n_ref;
    logic              r_cur_v, n_cur_v;
    logic [IW-1:0]     r_cur, n_cur;
    logic [31:0]       r_pidc, n_pidc;
    logic [LCW-1:0]    r_live, n_live;
    rrtt_pkg::t_result r_res, n_res;
    // pick-next search candidates
    logic              r_start_f, n_start_f;
    logic              r_aft_v, n_aft_v;
    logic [IW-1:0]     r_aft_s, n_aft_s;
    logic [31:0]       r_aft_p, n_aft_p;
    logic              r_nz_v, n_nz_v;
    logic [IW-1:0]     r_nz_s, n_nz_s;
    logic [31:0]       r_nz_p, n_nz_p;
    logic              r_any_v, n_any_v;
    logic [IW-1:0]     r_any_s, n_any_s;
    logic [31:0]       r_any_p, n_any_p;

    logic              qual;
    logic              last;
    logic [LCW+4:0]    live_ext;

    assign qual     = i_rd.live && (i_rd.pid != r_ref);
    assign last     = (r_chk == IW'(SLOTS - 1));
    assign live_ext = {5'd0, r_live};

    assign o_ready      = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = r_res;
    assign o_live_count = live_ext[4:0];
    assign o_wr_addr    = r_chk;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_tid     = r_tid;
        n_entry   = r_entry;
        n_sidx    = r_sidx;
        n_cnt     = r_cnt;
        n_dv      = r_dv;
        n_chk     = r_chk;
        n_fadr    = r_fadr;
        n_ref     = r_ref;
        n_cur_v   = r_cur_v;
        n_cur     = r_cur;
        n_pidc    = r_pidc;
        n_live    = r_live;
        n_res     = r_res;
        n_start_f = r_start_f;
        n_aft_v   = r_aft_v;
        n_aft_s   = r_aft_s;
        n_aft_p   = r_aft_p;
        n_nz_v    = r_nz_v;
        n_nz_s    = r_nz_s;
        n_nz_p    = r_nz_p;
        n_any_v   = r_any_v;
        n_any_s   = r_any_s;
        n_any_p   = r_any_p;
        o_rd_addr = r_cnt[IW-1:0];
        o_wr        = '0;
        o_wr.pid    = r_pidc;
        o_wr.entry  = r_entry;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd       = i_command;
                    n_tid       = i_task_id;
                    n_entry     = i_entry_addr;
                    n_sidx      = i_slot_index;
                    n_cnt       = '0;
                    n_dv        = 1'b0;
                    n_ref       = 32'd0;
                    n_res       = '0;
                    n_res.status = rrtt_pkg::ST_FAIL;
                    n_start_f   = 1'b0;
                    n_aft_v     = 1'b0;
                    n_nz_v      = 1'b0;
                    n_any_v     = 1'b0;
                    unique case (i_command)
                        rrtt_pkg::CMD_CREATE: begin
                            if (i_entry_addr != 64'd0 && i_stack_bytes != 32'd0) begin
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        rrtt_pkg::CMD_DESTROY, rrtt_pkg::CMD_SET_CUR: begin
                            n_state = S_SCAN;
                        end
                        rrtt_pkg::CMD_PICK: begin
                            if (r_cur_v) begin
                                n_fadr  = r_cur;
                                n_state = S_FETCH;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        rrtt_pkg::CMD_READ: begin
                            if ({1'b0, i_slot_index} < 9'(SLOTS)) begin
                                n_fadr  = i_slot_index[IW-1:0];
                                n_state = S_FETCH;
                            end else begin
                                n_res.status = rrtt_pkg::ST_OK;
                                n_res.slot   = i_slot_index[3:0];
                                n_state      = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_FETCH: begin
                o_rd_addr = r_fadr;
                n_state   = S_FWAIT;
            end

            S_FWAIT: begin
                if (r_cmd == rrtt_pkg::CMD_PICK) begin
                    n_ref   = i_rd.pid;
                    n_state = S_SCAN;
                end else begin
                    n_res.status = rrtt_pkg::ST_OK;
                    n_res.slot   = r_sidx[3:0];
                    if (i_rd.live) begin
                        n_res.pid   = i_rd.pid;
                        n_res.live  = 1'b1;
                        n_res.entry = i_rd.entry;
                    end
                    n_state = S_DONE;
                end
            end

            S_SCAN: begin
                // issue one read a cycle, check the slot read last cycle
                if (r_cnt < (IW + 1)'(SLOTS)) begin
                    n_cnt = r_cnt + (IW + 1)'(1);
                    n_dv  = 1'b1;
                    n_chk = r_cnt[IW-1:0];
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    unique case (r_cmd)
                        rrtt_pkg::CMD_CREATE: begin
                            if (!i_rd.live) begin
                                o_wr.create = 1'b1;
                                n_pidc      = r_pidc + 32'd1;
                                if (!r_cur_v) begin
                                    n_cur_v = 1'b1;
                                    n_cur   = r_chk;
                                end
                                n_live       = r_live + LCW'(1);
                                n_res.status = rrtt_pkg::ST_OK;
                                n_res.pid    = r_pidc;
                                n_res.slot   = f_slot4(r_chk);
                                n_state      = S_DONE;
                            end else if (last) begin
                                n_state = S_DONE;
                            end
                        end
                        rrtt_pkg::CMD_DESTROY: begin
                            if (i_rd.pid == r_tid) begin
                                o_wr.free = 1'b1;
                                if (i_rd.live) begin
                                    n_live = r_live - LCW'(1);
                                end
                                if (r_cur_v && r_cur == r_chk) begin
                                    n_cur_v = 1'b0;
                                end
                                n_res.status = rrtt_pkg::ST_OK;
                                n_state      = S_DONE;
                            end else if (last) begin
                                n_state = S_DONE;
                            end
                        end
                        rrtt_pkg::CMD_SET_CUR: begin
                            if (i_rd.pid == r_tid) begin
                                n_cur_v      = 1'b1;
                                n_cur        = r_chk;
                                n_res.status = rrtt_pkg::ST_OK;
                                n_res.pid    = i_rd.pid;
                                n_res.slot   = f_slot4(r_chk);
                                n_state      = S_DONE;
                            end else if (last) begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            if (i_rd.pid == r_ref) begin
                                n_start_f = 1'b1;
                            end
                            if (qual && r_start_f && !r_aft_v) begin
                                n_aft_v = 1'b1;
                                n_aft_s = r_chk;
                                n_aft_p = i_rd.pid;
                            end
                            if (qual && r_chk != '0 && !r_nz_v) begin
                                n_nz_v = 1'b1;
                                n_nz_s = r_chk;
                                n_nz_p = i_rd.pid;
                            end
                            if (qual && !r_any_v) begin
                                n_any_v = 1'b1;
                                n_any_s = r_chk;
                                n_any_p = i_rd.pid;
                            end
                            if (last) begin
                                n_state = S_PICK;
                            end
                        end
                    endcase
                end
            end

            S_PICK: begin
                n_state = S_DONE;
                priority if (r_start_f && r_aft_v) begin
                    n_res.status = rrtt_pkg::ST_OK;
                    n_res.pid    = r_aft_p;
                    n_res.slot   = f_slot4(r_aft_s);
                end else if (!r_start_f && r_nz_v) begin
                    n_res.status = rrtt_pkg::ST_OK;
                    n_res.pid    = r_nz_p;
                    n_res.slot   = f_slot4(r_nz_s);
                end else if (r_any_v) begin
                    n_res.status = rrtt_pkg::ST_OK;
                    n_res.pid    = r_any_p;
                    n_res.slot   = f_slot4(r_any_s);
                end else if (r_cur_v) begin
                    n_res.status = rrtt_pkg::ST_OK;
                    n_res.pid    = r_ref;
                    n_res.slot   = f_slot4(r_cur);
                end else begin
                    n_res.status = rrtt_pkg::ST_NONE;
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur_v <= 1'b0;
            r_cur   <= '0;
            r_pidc  <= 32'd1;
            r_live  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur_v <= n_cur_v;
            r_cur   <= n_cur;
            r_pidc  <= n_pidc;
            r_live  <= n_live;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_tid     <= n_tid;
        r_entry   <= n_entry;
        r_sidx    <= n_sidx;
        r_cnt     <= n_cnt;
        r_chk     <= n_chk;
        r_fadr    <= n_fadr;
        r_ref     <= n_ref;
        r_res     <= n_res;
        r_start_f <= n_start_f;
        r_aft_v   <= n_aft_v;
        r_aft_s   <= n_aft_s;
        r_aft_p   <= n_aft_p;
        r_nz_v    <= n_nz_v;
        r_nz_s    <= n_nz_s;
        r_nz_p    <= n_nz_p;
        r_any_v   <= n_any_v;
        r_any_s   <= n_any_s;
        r_any_p   <= n_any_p;
    end

endmodule

@@ hdl/round_robin_task_table.sv @@
`timescale 1ns / 1ps

// Round-robin task table: SLOTS task slots (pid, live flag, entry address)
// with a current-slot pointer and a pid counter that starts at 1.
// Input channel (i_valid / o_ready): one command per transfer - create,
// destroy, set current, pick next or read slot, with its arguments.
// Output channel (o_valid / i_ready): exactly one result per command,
// carrying status, pid, slot, live flag, entry and the live-slot count.
// One command is in work at a time. A rejected or unknown command goes
// straight to its result; read slot fetches its slot when the index is in
// range; create, destroy and set current scan the slots until a hit or the
// last slot; pick next first fetches the current slot's pid when a slot is
// current, then scans all slots. o_ready returns when the result is loaded
// into the output register. Each scan reads the pid memory one slot per
// cycle through its single read port.
// The result is held in an output register, so the next command is taken
// while it waits. When the receiver stalls, the result holds; a finished
// command then waits in the controller until the register frees, and
// o_ready stays low.
// Reset (synchronous, active low) frees all slots, clears the current
// pointer and sets the pid counter to 1; no clearing pass is needed.
module round_robin_task_table #(
    parameter int SLOTS = rrtt_pkg::SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_task_id,
    input  logic [63:0] i_entry_addr,
    input  logic [31:0] i_stack_bytes,
    input  logic [7:0]  i_slot_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_pid,
    output logic [3:0]  o_out_slot,
    output logic        o_out_live,
    output logic [63:0] o_out_entry,
    output logic [4:0]  o_live_count
);

    localparam int IW = $clog2(SLOTS);

    logic               res_valid;
    logic               res_ready;
    rrtt_pkg::t_result  res;
    logic [4:0]         res_live_count;
    logic [IW-1:0]      rd_addr;
    rrtt_pkg::t_rd_data rd_data;
    logic [IW-1:0]      wr_addr;
    rrtt_pkg::t_wr_req  wr_req;

    logic               r_ov;
    rrtt_pkg::t_result  r_res;
    logic [4:0]         r_live_count;

    // sequencer: decodes the command and walks the slots
    rrtt_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_task_id    (i_task_id),
        .i_entry_addr (i_entry_addr),
        .i_stack_bytes(i_stack_bytes),
        .i_slot_index (i_slot_index),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_live_count (res_live_count),
        .o_rd_addr    (rd_addr),
        .i_rd         (rd_data),
        .o_wr_addr    (wr_addr),
        .o_wr         (wr_req)
    );

    // slot storage: pid and entry memories plus live flags
    rrtt_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_addr(rd_addr),
        .o_rd     (rd_data),
        .i_wr_addr(wr_addr),
        .i_wr     (wr_req)
    );

    // output register: load when empty or being drained in this cycle
    assign res_ready = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // hold the payload until the transfer completes
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_res        <= res;
            r_live_count <= res_live_count;
        end
    end

    assign o_valid      = r_ov;
    assign o_status     = r_res.status;
    assign o_out_pid    = r_res.pid;
    assign o_out_slot   = r_res.slot;
    assign o_out_live   = r_res.live;
    assign o_out_entry  = r_res.entry;
    assign o_live_count = r_live_count;

endmodule
